FILE: rtl/sspd_pkg.sv
// Shared types and constants of the seek-and-drive controller.
package sspd_pkg;

  localparam int NOW_W   = 32;   // timestamp field
  localparam int ERR_W   = 11;   // position error, signed
  localparam int GAIN_W  = 10;   // PID gains
  localparam int SPEED_W = 8;    // drive levels
  localparam int SIDE_W  = 4;    // side correction multiplier
  localparam int MS_W    = 16;   // timeout and sweep periods
  localparam int NUM_W   = 21;   // |error step| * deriv_gain
  localparam int ACC_W   = 43;   // PID sum before scaling, signed
  localparam int MAG_W   = 42;   // magnitude of the PID sum
  localparam int CORR_W  = 16;   // correction, signed
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] SCALE_DIV    = 8'd100;
  localparam logic [SPEED_W-1:0] SEARCH_LEVEL = 8'd100;
  localparam logic [SPEED_W-1:0] LEVEL_MAX    = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TMO    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_MS    = 3'd7;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] prior_err;
    logic [31:0]             integ_sum;
    logic [GAIN_W-1:0]       prop_gain;
    logic [GAIN_W-1:0]       integ_gain;
    logic [GAIN_W-1:0]       deriv_gain;
  } pid_req_t;

  typedef struct packed {
    logic [31:0]       integ_sum;
    logic [CORR_W-1:0] corr;
  } pid_rsp_t;

endpackage

FILE: rtl/sspd_in_if.sv
// Input channel: timestamp and four sensor bits.
interface sspd_in_if;
  logic                     valid;
  logic                     ready;
  logic [sspd_pkg::NOW_W-1:0] now_ms;
  logic                     sense_outer_left;
  logic                     sense_center_left;
  logic                     sense_center_right;
  logic                     sense_outer_right;

  modport source(output valid, now_ms, sense_outer_left, sense_center_left,
                 sense_center_right, sense_outer_right, input ready);
  modport sink(input valid, now_ms, sense_outer_left, sense_center_left,
               sense_center_right, sense_outer_right, output ready);
endinterface

FILE: rtl/sspd_out_if.sv
// Output channel: four PWM levels and the mode.
interface sspd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_forward;
  logic [7:0] left_reverse;
  logic [7:0] right_forward;
  logic [7:0] right_reverse;
  logic       mode;

  modport source(output valid, left_forward, left_reverse, right_forward,
                 right_reverse, mode, input ready);
  modport sink(input valid, left_forward, left_reverse, right_forward,
               right_reverse, mode, output ready);
endinterface

FILE: rtl/sspd_pid_core.sv
// Bit-serial PID arithmetic: integral MAC, derivative divide, scale by 100.
module sspd_pid_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dt,
  input  sspd_pkg::pid_req_t   req,
  output logic                 done,
  output sspd_pkg::pid_rsp_t   rsp
);
  import sspd_pkg::*;

  localparam int MD_CYC  = (TIME_BITS > NUM_W) ? TIME_BITS : NUM_W;
  localparam int CNT_MAX = (MD_CYC > MAG_W) ? MD_CYC : MAG_W;
  localparam int CNT_W   = $clog2(CNT_MAX);

  typedef enum logic [7:0] {
    C_IDLE   = 8'b0000_0001,
    C_SETUP  = 8'b0000_0010,
    C_MULDIV = 8'b0000_0100,
    C_DADD   = 8'b0000_1000,
    C_IGAIN  = 8'b0001_0000,
    C_MAGS   = 8'b0010_0000,
    C_SCALE  = 8'b0100_0000,
    C_DONE   = 8'b1000_0000
  } core_state_t;

  core_state_t             state;
  logic [CNT_W-1:0]        cnt;
  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        diff_abs;
  logic                    dneg;
  logic [GAIN_W-1:0]       prop;
  logic [GAIN_W-1:0]       dgain;
  logic [GAIN_W-1:0]       ig_sr;
  logic [TIME_BITS-1:0]    dt_r;
  logic [TIME_BITS-1:0]    dt_sr;
  logic [31:0]             isum;
  logic [31:0]             errsh;
  logic [MD_CYC-1:0]       num_sr;
  logic [TIME_BITS:0]      rem;
  logic [NUM_W-1:0]        quo;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        op;
  logic [MAG_W-1:0]        mag_sr;
  logic [6:0]              rem100;
  logic [CORR_W-1:0]       q16;
  logic                    cneg;

  logic signed [ERR_W:0]        diff;
  logic [NUM_W-1:0]             num;
  logic signed [2*ERR_W-1:0]    prop_err;
  logic [TIME_BITS:0]           r2;
  logic                         r2_ge;
  logic [7:0]                   r8;
  logic [ACC_W-1:0]             dterm;
  logic [ACC_W-1:0]             acc_abs;

  assign diff     = {req.err[ERR_W-1], req.err} - {req.prior_err[ERR_W-1], req.prior_err};
  assign num      = NUM_W'(diff_abs * dgain);
  assign prop_err = $signed({1'b0, prop}) * err;
  assign r2       = {rem[TIME_BITS-1:0], num_sr[MD_CYC-1]};
  assign r2_ge    = r2 >= {1'b0, dt_r};
  assign r8       = {rem100, mag_sr[MAG_W-1]};
  assign dterm    = (dt_r == '0) ? '0 :
                    (dneg ? -{{(ACC_W-NUM_W){1'b0}}, quo} : {{(ACC_W-NUM_W){1'b0}}, quo});
  assign acc_abs  = acc[ACC_W-1] ? -acc : acc;

  assign done          = (state == C_DONE);
  assign rsp.integ_sum = isum;
  assign rsp.corr      = cneg ? -q16 : q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            err      <= req.err;
            dneg     <= diff[ERR_W];
            diff_abs <= diff[ERR_W] ? ERR_W'(-diff) : diff[ERR_W-1:0];
            prop     <= req.prop_gain;
            dgain    <= req.deriv_gain;
            ig_sr    <= req.integ_gain;
            isum     <= req.integ_sum;
            dt_r     <= dt;
            dt_sr    <= dt;
            state    <= C_SETUP;
          end
        end
        C_SETUP: begin
          num_sr <= {{(MD_CYC-NUM_W){1'b0}}, num};
          acc    <= {{(ACC_W-2*ERR_W){prop_err[2*ERR_W-1]}}, prop_err};
          errsh  <= {{(32-ERR_W){err[ERR_W-1]}}, err};
          rem    <= '0;
          cnt    <= '0;
          state  <= C_MULDIV;
        end
        C_MULDIV: begin
          // integral MAC, one dt bit per cycle
          if (dt_sr[0]) isum <= isum + errsh;
          errsh <= {errsh[30:0], 1'b0};
          dt_sr <= dt_sr >> 1;
          // derivative restoring divide, one quotient bit per cycle
          if (r2_ge) begin
            rem <= r2 - {1'b0, dt_r};
            quo <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            rem <= r2;
            quo <= {quo[NUM_W-2:0], 1'b0};
          end
          num_sr <= {num_sr[MD_CYC-2:0], 1'b0};
          if (cnt == CNT_W'(MD_CYC - 1)) begin
            cnt   <= '0;
            state <= C_DADD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        C_DADD: begin
          acc   <= acc + dterm;
          op    <= {{(ACC_W-32){isum[31]}}, isum};
          state <= C_IGAIN;
        end
        C_IGAIN: begin
          if (ig_sr[0]) acc <= acc + op;
          op    <= {op[ACC_W-2:0], 1'b0};
          ig_sr <= ig_sr >> 1;
          if (cnt == CNT_W'(GAIN_W - 1)) begin
            cnt   <= '0;
            state <= C_MAGS;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        C_MAGS: begin
          cneg   <= acc[ACC_W-1];
          mag_sr <= acc_abs[MAG_W-1:0];
          rem100 <= '0;
          state  <= C_SCALE;
        end
        C_SCALE: begin
          if (r8 >= SCALE_DIV) begin
            rem100 <= 7'(r8 - SCALE_DIV);
            q16    <= {q16[CORR_W-2:0], 1'b1};
          end else begin
            rem100 <= r8[6:0];
            q16    <= {q16[CORR_W-2:0], 1'b0};
          end
          mag_sr <= {mag_sr[MAG_W-2:0], 1'b0};
          if (cnt == CNT_W'(MAG_W - 1)) begin
            cnt   <= '0;
            state <= C_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        C_DONE: state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sensor_seek_pid_motor_drive.sv
// Top level: search sweep / attack PID drive controller.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      now_ms, sense_outer_left .. sense_outer_right
//  out_ch   out  valid/ready      left/right forward/reverse levels, mode
//  cfg      in   cfg_we           cfg_index, cfg_data (8 registers)
//
// A search step or a return to search goes T_IDLE -> T_FIN. An attack PID
// step also waits in T_PID for the PID core, which is bit-serial: integral
// multiply / derivative divide and the 42-bit serial divide by 100. One
// transaction is in work at a time; a finished result waits in the output
// register while the next one runs. Reset (rst, synchronous) restores register
// defaults and clears the sequencing, mode, timing and PID history state.
module sensor_seek_pid_motor_drive #(
  parameter int TIME_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  sspd_in_if.sink                    in_ch,
  sspd_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [sspd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sspd_pkg::CFG_W-1:0] cfg_data
);
  import sspd_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_PID  = 3'b010,
    T_FIN  = 3'b100
  } top_state_t;

  // position error of a nonzero sensor set: weighted mean, truncated
  function automatic logic signed [ERR_W-1:0] err_of(input logic [3:0] s);
    logic signed [ERR_W-1:0] e;
    unique case (s)
      4'd1:    e = -11'sd750;
      4'd2:    e = -11'sd250;
      4'd3:    e = -11'sd500;
      4'd4:    e =  11'sd250;
      4'd5:    e = -11'sd250;
      4'd7:    e = -11'sd250;
      4'd8:    e =  11'sd750;
      4'd10:   e =  11'sd250;
      4'd11:   e = -11'sd83;
      4'd12:   e =  11'sd500;
      4'd13:   e =  11'sd83;
      4'd14:   e =  11'sd250;
      default: e = '0;
    endcase
    return e;
  endfunction

  // signed 16-bit level sum to {forward, reverse}
  function automatic logic [2*SPEED_W-1:0] motor(input logic [15:0] v);
    logic [15:0]        m;
    logic [SPEED_W-1:0] l;
    m = v[15] ? -v : v;
    l = (|m[15:8]) ? LEVEL_MAX : m[7:0];
    return v[15] ? {{SPEED_W{1'b0}}, l} : {l, {SPEED_W{1'b0}}};
  endfunction

  // configuration registers
  logic [GAIN_W-1:0]  prop_gain, integ_gain, deriv_gain;
  logic [SPEED_W-1:0] base_level, front_speed;
  logic [SIDE_W-1:0]  side_gain;
  logic [MS_W-1:0]    lost_timeout_ms, sweep_ms;

  // controller state
  top_state_t              state;
  logic                    attack_mode;
  logic                    sweep_right;
  logic [TIME_BITS-1:0]    sweep_start, last_pid_time, last_seen_time, lost_time;
  logic signed [ERR_W-1:0] prior_error;
  logic [31:0]             integ_sum;
  logic [SPEED_W-1:0]      lvl [4];
  logic [3:0]              sense_r;

  logic               out_valid;
  logic [SPEED_W-1:0] out_lvl [4];
  logic               out_mode;

  logic                    in_acc;
  logic [TIME_BITS-1:0]    now_t;
  logic [3:0]              sense;
  logic                    any_seen;
  logic signed [ERR_W-1:0] err;
  logic                    sweep_flip;
  logic                    pid_go;
  logic                    pid_done;
  pid_req_t                pid_req;
  pid_rsp_t                pid_rsp;

  // drive mix of a finished PID step
  logic                   both_center, outer_only;
  logic [SPEED_W-1:0]     speed;
  logic [SIDE_W-1:0]      mult;
  logic [15:0]            corr_k;
  logic [2*SPEED_W-1:0]   lpair, rpair;

  assign in_ch.ready = (state == T_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign now_t       = in_ch.now_ms[TIME_BITS-1:0];
  assign sense       = {in_ch.sense_outer_right, in_ch.sense_center_right,
                        in_ch.sense_center_left, in_ch.sense_outer_left};
  assign any_seen    = |sense;
  assign err         = any_seen ? err_of(sense) : prior_error;
  assign sweep_flip  = (now_t - sweep_start) >= TIME_BITS'(sweep_ms);
  assign pid_go      = in_acc && attack_mode &&
                       !(lost_time > TIME_BITS'(lost_timeout_ms));

  assign pid_req.err        = err;
  assign pid_req.prior_err  = prior_error;
  assign pid_req.integ_sum  = integ_sum;
  assign pid_req.prop_gain  = prop_gain;
  assign pid_req.integ_gain = integ_gain;
  assign pid_req.deriv_gain = deriv_gain;

  sspd_pid_core #(.TIME_BITS(TIME_BITS)) u_pid (
    .clk   (clk),
    .rst   (rst),
    .start (pid_go),
    .dt    (now_t - last_pid_time),
    .req   (pid_req),
    .done  (pid_done),
    .rsp   (pid_rsp)
  );

  assign both_center = sense_r[1] && sense_r[2];
  assign outer_only  = (sense_r[0] || sense_r[3]) && !(sense_r[1] || sense_r[2]);
  assign speed       = both_center ? front_speed : base_level;
  assign mult        = (!both_center && outer_only) ? side_gain : SIDE_W'(1);
  assign corr_k      = 16'(pid_rsp.corr * {12'b0, mult});
  assign lpair       = motor({8'b0, speed} + corr_k);
  assign rpair       = motor({8'b0, speed} - corr_k);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= 10'd100;
      integ_gain      <= 10'd0;
      deriv_gain      <= 10'd100;
      base_level      <= 8'd200;
      front_speed     <= 8'd255;
      side_gain       <= 4'd5;
      lost_timeout_ms <= 16'd2000;
      sweep_ms        <= 16'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   prop_gain       <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain      <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain      <= cfg_data[GAIN_W-1:0];
        REG_BASE_LEVEL:  base_level      <= cfg_data[SPEED_W-1:0];
        REG_FRONT_SPEED: front_speed     <= cfg_data[SPEED_W-1:0];
        REG_SIDE_GAIN:   side_gain       <= cfg_data[SIDE_W-1:0];
        REG_LOST_TMO:    lost_timeout_ms <= cfg_data[MS_W-1:0];
        REG_SWEEP_MS:    sweep_ms        <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // mode control and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= T_IDLE;
      attack_mode    <= 1'b0;
      sweep_right    <= 1'b1;
      sweep_start    <= '0;
      last_pid_time  <= '0;
      last_seen_time <= '0;
      lost_time      <= '0;
      prior_error    <= '0;
      integ_sum      <= '0;
      for (int i = 0; i < 4; i++) lvl[i] <= '0;
      out_valid      <= 1'b0;
    end else begin
      // T_FIN either reloads the output register or leaves a stalled one alone
      if (out_ch.valid && out_ch.ready && state != T_FIN) out_valid <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (in_acc) begin
            sense_r <= sense;
            state   <= T_FIN;
            if (!attack_mode) begin
              if (any_seen) begin
                attack_mode    <= 1'b1;
                last_pid_time  <= now_t;
                last_seen_time <= now_t;
                lost_time      <= '0;
              end else begin
                if (sweep_flip) begin
                  sweep_start <= now_t;
                  sweep_right <= !sweep_right;
                end
                // right turn after the update: left back, right forward
                if (sweep_right ^ sweep_flip) begin
                  lvl[0] <= '0;           lvl[1] <= SEARCH_LEVEL;
                  lvl[2] <= SEARCH_LEVEL; lvl[3] <= '0;
                end else begin
                  lvl[0] <= SEARCH_LEVEL; lvl[1] <= '0;
                  lvl[2] <= '0;           lvl[3] <= SEARCH_LEVEL;
                end
              end
            end else if (!pid_go) begin
              // target lost too long: back to search, levels held
              attack_mode <= 1'b0;
              sweep_start <= now_t;
            end else begin
              last_pid_time <= now_t;
              if (any_seen) begin
                lost_time      <= '0;
                last_seen_time <= now_t;
              end else begin
                lost_time <= now_t - last_seen_time;
              end
              prior_error <= err;
              state       <= T_PID;
            end
          end
        end
        T_PID: begin
          if (pid_done) begin
            integ_sum <= pid_rsp.integ_sum;
            lvl[0]    <= lpair[2*SPEED_W-1:SPEED_W];
            lvl[1]    <= lpair[SPEED_W-1:0];
            lvl[2]    <= rpair[2*SPEED_W-1:SPEED_W];
            lvl[3]    <= rpair[SPEED_W-1:0];
            state     <= T_FIN;
          end
        end
        T_FIN: begin
          // hand the result over once the output register is free
          if (!out_valid || out_ch.ready) begin
            for (int i = 0; i < 4; i++) out_lvl[i] <= lvl[i];
            out_mode  <= attack_mode;
            out_valid <= 1'b1;
            state     <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.left_forward  = out_lvl[0];
  assign out_ch.left_reverse  = out_lvl[1];
  assign out_ch.right_forward = out_lvl[2];
  assign out_ch.right_reverse = out_lvl[3];
  assign out_ch.mode          = out_mode;

endmodule
